### rtl/plle_pkg.sv
// Shared types, constants and command/status structs of the poll loop load estimator.
package plle_pkg;

    localparam int WINDOW_SLOTS = 8;
    localparam logic [63:0] WINDOW_CYCLES_RST = 64'd2000000000;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_POLL  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] n_pkts;
        logic [63:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [2:0]  window_slot;
        logic [31:0] busy_count;
        logic [63:0] capacity_count;
    } t_out;

    typedef enum logic [1:0] {
        DIV_TICKS = 2'd0,
        DIV_PKTS  = 2'd1,
        DIV_IDLE  = 2'd2
    } t_div_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_DIV_P,
        ST_DIV_I,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACCUM,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic     in_open;
        logic     clr_avg;
        logic     div_start;
        t_div_sel div_sel;
        logic     ld_avg_t;
        logic     ld_avg_p;
        logic     mul_lo;
        logic     mul_hi;
        logic     accum;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic bp_zero;
        logic at_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/plle_div.sv
// Restoring 64-bit unsigned divider that produces one quotient bit per cycle.
module plle_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_q[63]} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // A set top bit means the trial subtraction went negative.
            if (!w_trial[64]) begin
                r_rem <= w_trial[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[62:0], r_q[63]};
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### rtl/plle_dp.sv
// Datapath: window sums, shared divider, split multiplier and the result register.
module plle_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plle_pkg::t_cmd  i_cmd,
    output plle_pkg::t_sts  o_sts,
    input  logic            i_cfg_wen,
    input  logic [63:0]     i_cfg_wdata,
    input  logic            i_in_valid,
    input  plle_pkg::t_in   i_in,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output plle_pkg::t_out  o_out
);

    logic [63:0] r_window_cycles;
    logic [31:0] r_pending;
    logic [63:0] r_last_stamp;
    logic [31:0] r_window_pkts;
    logic [31:0] r_busy_passes;
    logic [63:0] r_busy_ticks;
    logic [2:0]  r_slot;
    logic [63:0] r_avg_t;
    logic [31:0] r_avg_p;
    logic [63:0] r_prod;
    logic [31:0] r_hi;
    logic        r_out_valid;
    plle_pkg::t_out r_out;

    logic        w_take;
    logic [63:0] w_idle;
    logic [63:0] w_dividend;
    logic [63:0] w_divisor;
    logic        w_div_done;
    logic [63:0] w_quot;
    logic [63:0] w_lo_prod;
    logic [31:0] w_hi_prod;
    logic        w_out_free;

    assign w_take = i_in_valid && i_cmd.in_open;
    assign w_idle = (r_busy_ticks < r_window_cycles) ? (r_window_cycles - r_busy_ticks) : '0;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.div_sel)
            plle_pkg::DIV_TICKS: begin
                w_dividend = r_busy_ticks;
                w_divisor  = {32'd0, r_busy_passes};
            end
            plle_pkg::DIV_PKTS: begin
                w_dividend = {32'd0, r_window_pkts};
                w_divisor  = {32'd0, r_busy_passes};
            end
            plle_pkg::DIV_IDLE: begin
                w_dividend = w_idle;
                w_divisor  = r_avg_t;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = '0;
            end
        endcase
    end

    plle_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // The 64 x 32 product is taken in two halves; only its low 64 bits matter.
    assign w_lo_prod = 64'(w_quot[31:0]) * 64'(r_avg_p);
    assign w_hi_prod = w_quot[63:32] * r_avg_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_cycles <= plle_pkg::WINDOW_CYCLES_RST;
            r_pending       <= '0;
            r_last_stamp    <= '0;
            r_window_pkts   <= '0;
            r_busy_passes   <= '0;
            r_busy_ticks    <= '0;
            r_slot          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_window_cycles <= i_cfg_wdata;
            end
            if (w_take && i_in.req_type == plle_pkg::REQ_ADD) begin
                r_pending <= r_pending + {16'd0, i_in.n_pkts};
            end
            if (w_take && i_in.req_type == plle_pkg::REQ_POLL) begin
                if (r_pending != 32'd0) begin
                    r_window_pkts <= r_window_pkts + r_pending;
                    r_busy_passes <= r_busy_passes + 32'd1;
                    r_busy_ticks  <= r_busy_ticks + (i_in.timestamp - r_last_stamp);
                    r_pending     <= '0;
                end
                r_last_stamp <= i_in.timestamp;
            end
            if (i_cmd.finish) begin
                r_window_pkts <= '0;
                r_busy_passes <= '0;
                r_busy_ticks  <= '0;
                r_slot        <= (r_slot == 3'(plle_pkg::WINDOW_SLOTS - 1)) ? 3'd0 : r_slot + 3'd1;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_avg) begin
            r_avg_t <= '0;
        end else if (i_cmd.ld_avg_t) begin
            r_avg_t <= w_quot;
        end
        if (i_cmd.ld_avg_p) begin
            r_avg_p <= w_quot[31:0];
        end
        if (i_cmd.mul_lo) begin
            r_prod <= w_lo_prod;
        end else if (i_cmd.accum) begin
            r_prod <= r_prod + {r_hi, 32'd0};
        end
        if (i_cmd.mul_hi) begin
            r_hi <= w_hi_prod;
        end
        if (i_cmd.finish) begin
            r_out.window_slot <= r_slot;
            if (r_avg_t == 64'd0) begin
                r_out.busy_count     <= '0;
                r_out.capacity_count <= '0;
            end else begin
                r_out.busy_count     <= r_window_pkts;
                r_out.capacity_count <= r_prod + {32'd0, r_window_pkts};
            end
        end
    end

    assign o_sts.bp_zero  = (r_busy_passes == 32'd0);
    assign o_sts.at_zero  = (r_avg_t == 64'd0);
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/plle_ctrl.sv
// Controller: sequences the window-close computation and opens the input channel.
module plle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_req_type,
    input  plle_pkg::t_sts i_sts,
    output plle_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);

    plle_pkg::t_state r_state;
    plle_pkg::t_state n_state;
    logic             w_close;

    assign w_close = i_in_valid && (i_req_type == plle_pkg::REQ_CLOSE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            plle_pkg::ST_IDLE: begin
                if (w_close) begin
                    n_state = i_sts.bp_zero ? plle_pkg::ST_FINISH : plle_pkg::ST_DIV_T;
                end
            end
            plle_pkg::ST_DIV_T: begin
                if (i_sts.div_done) begin
                    n_state = plle_pkg::ST_DIV_P;
                end
            end
            plle_pkg::ST_DIV_P: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.at_zero ? plle_pkg::ST_FINISH : plle_pkg::ST_DIV_I;
                end
            end
            plle_pkg::ST_DIV_I: begin
                if (i_sts.div_done) begin
                    n_state = plle_pkg::ST_MUL_LO;
                end
            end
            plle_pkg::ST_MUL_LO: n_state = plle_pkg::ST_MUL_HI;
            plle_pkg::ST_MUL_HI: n_state = plle_pkg::ST_ACCUM;
            plle_pkg::ST_ACCUM:  n_state = plle_pkg::ST_FINISH;
            plle_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = plle_pkg::ST_IDLE;
                end
            end
            default: n_state = plle_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = plle_pkg::DIV_TICKS;
        case (r_state)
            plle_pkg::ST_IDLE: begin
                o_cmd.in_open = 1'b1;
                if (w_close) begin
                    o_cmd.clr_avg   = 1'b1;
                    o_cmd.div_start = !i_sts.bp_zero;
                end
            end
            plle_pkg::ST_DIV_T: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_avg_t  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = plle_pkg::DIV_PKTS;
                end
            end
            plle_pkg::ST_DIV_P: begin
                o_cmd.div_sel = plle_pkg::DIV_IDLE;
                if (i_sts.div_done) begin
                    o_cmd.ld_avg_p  = 1'b1;
                    o_cmd.div_start = !i_sts.at_zero;
                end
            end
            plle_pkg::ST_DIV_I:  o_cmd.div_sel = plle_pkg::DIV_IDLE;
            plle_pkg::ST_MUL_LO: o_cmd.mul_lo = 1'b1;
            plle_pkg::ST_MUL_HI: o_cmd.mul_hi = 1'b1;
            plle_pkg::ST_ACCUM:  o_cmd.accum = 1'b1;
            plle_pkg::ST_FINISH: o_cmd.finish = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = (r_state != plle_pkg::ST_IDLE);

endmodule

### rtl/poll_loop_load_estimator.sv
// Top level of the poll loop load estimator: controller, datapath and ports.
//
// Input channel (i_in_valid, o_in_stall, i_in) carries add, poll-end and
// window-close transactions. Add and poll-end transactions update the window
// sums in the cycle they are taken, and the next transaction may follow at once.
// A window-close transaction yields one result on the output channel
// (o_out_valid, i_out_stall, o_out). When the window had busy passes, it runs
// three 64-bit divisions on the one shared bit-serial divider, two multiply
// halves and a final add. A window with no busy pass goes straight to the final
// step, and one with zero average ticks per pass skips the third division and
// the multiply. o_in_stall stays high for that whole computation.
// The result sits in an output register; while the receiver stalls it holds,
// and add and poll-end transactions are still taken. A later close waits in
// its final step until the register is free.
// The user must write window_cycles (i_cfg_wen, i_cfg_wdata) only while idle;
// the block does not enforce it. A synchronous reset clears all sums, the
// slot index and the output valid, and sets window_cycles to 2000000000.
module poll_loop_load_estimator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wen,
    input  logic [63:0]    i_cfg_wdata,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  plle_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output plle_pkg::t_out o_out
);

    plle_pkg::t_cmd w_cmd;
    plle_pkg::t_sts w_sts;

    plle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    plle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

### rtl/plle_checker.sv
// Port-level checks of the poll loop load estimator and their binding.
module plle_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input plle_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input plle_pkg::t_out o_out
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.req_type == plle_pkg::REQ_CLOSE |=> o_in_stall)
        else $error("window close did not start its computation");

    a_update_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.req_type != plle_pkg::REQ_CLOSE |=> !o_in_stall)
        else $error("input closed after a single-cycle transaction");

    a_zero_busy_zero_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.busy_count == 32'd0 |-> o_out.capacity_count == 64'd0)
        else $error("capacity without packets");

endmodule

bind poll_loop_load_estimator plle_checker u_plle_checker (.*);
